// File: src/imu_fd_pkg.sv
// imu_fd_pkg: shared types, constants and the crc-8 step for the imu frame deframer
// used by imu_fd_skid and imu_frame_deframer_core; no other dependencies
`timescale 1ns / 1ps
`default_nettype none

package imu_fd_pkg;

  localparam int CrcSpan    = 30;
  localparam int FieldFirst = 2;
  localparam int FieldCount = 17;

  localparam logic [7:0] CrcPoly     = 8'h07;
  localparam logic [7:0] CrcMsb      = 8'h80;
  localparam logic [7:0] MarkFirst   = 8'hcc;
  localparam logic [7:0] MarkSecond  = 8'hff;
  localparam logic [7:0] HeaderByte  = 8'haa;
  localparam logic [7:0] TrailerByte = 8'hbb;
  localparam logic [7:0] PosMax      = 8'hff;
  localparam logic [7:0] HeaderPos   = 8'd0;
  localparam logic [7:0] TrailerPos  = 8'(CrcSpan - 1);
  localparam logic [7:0] CrcPos      = 8'(CrcSpan);
  localparam logic [7:0] MinLength   = 8'(CrcSpan + 1);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_stamp;
    logic [7:0]         speed_byte;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               crc_good;
    logic               markers_good;
    logic [7:0]         frame_length;
    logic               length_good;
  } frame_res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcMsb) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/imu_fd_skid.sv
// imu_fd_skid: output register plus skid entry for decoded frame transactions
// depends on imu_fd_pkg for the result struct
`timescale 1ns / 1ps
`default_nettype none

module imu_fd_skid (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   res_valid_i,
  input  wire imu_fd_pkg::frame_res_t res_i,
  output logic                        skid_full_o,
  output logic                        out_valid_o,
  output imu_fd_pkg::frame_res_t      out_res_o,
  input  wire logic                   out_stall_i
);
  import imu_fd_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  frame_res_t out_res_q, out_res_d;
  frame_res_t skid_res_q, skid_res_d;
  logic       out_free;

  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_res_d   = res_i;
      end
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

// File: src/imu_frame_deframer_core.sv
// imu_frame_deframer_core: top level of the imu byte-stream deframer with crc-8 check
// depends on imu_fd_pkg and imu_fd_skid
//
// usage:
//   rx channel (rx_valid_i / rx_stall_o / rx_byte_i) takes one serial byte per transaction.
//   a frame ends on 0xff directly after 0xcc; that byte yields one transaction on the frame
//   channel (frame_valid_o / frame_stall_i and the field outputs), other bytes yield none.
//   the result of the closing byte is registered in the output register or the skid entry.
//   throughput: one byte per cycle while rx_stall_o is low; all per-byte work (crc-8 step, field
//   capture, marker checks) is one combinational pass into the frame state and the output register.
//   when the receiver stalls, a second result is held in a skid entry; rx_stall_o rises only
//   while that skid entry is occupied.
//   reset: frame state clears to zero, no result pending; the block accepts bytes at once.
//   after each closing byte all frame state returns to its reset value.
`timescale 1ns / 1ps
`default_nettype none

module imu_frame_deframer_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         rx_valid_i,
  output logic              rx_stall_o,
  input  wire logic [7:0]   rx_byte_i,
  output logic              frame_valid_o,
  input  wire logic         frame_stall_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic [31:0]       time_stamp_o,
  output logic [7:0]        speed_byte_o,
  output logic signed [15:0] gyro_x_o,
  output logic signed [15:0] gyro_y_o,
  output logic signed [15:0] gyro_z_o,
  output logic              crc_good_o,
  output logic              markers_good_o,
  output logic [7:0]        frame_length_o,
  output logic              length_good_o
);
  import imu_fd_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic       mark_q, mark_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] field_q [FieldCount];
  logic [7:0] field_d [FieldCount];
  logic       hdr_q, hdr_d;
  logic       trl_q, trl_d;
  logic       crc_ok_q, crc_ok_d;

  logic       accept;
  logic       frame_end;
  logic [7:0] len;
  logic       skid_full;
  frame_res_t res;
  frame_res_t out_res;

  assign accept = rx_valid_i && !skid_full;

  always_comb begin
    len       = (pos_q != PosMax) ? pos_q + 8'd1 : PosMax;
    frame_end = accept && mark_q && (rx_byte_i == MarkSecond);
    hdr_d     = hdr_q;
    trl_d     = trl_q;
    crc_d     = crc_q;
    crc_ok_d  = crc_ok_q;
    field_d   = field_q;
    if (pos_q == HeaderPos) begin
      hdr_d = (rx_byte_i == HeaderByte);
    end
    if (pos_q == TrailerPos) begin
      trl_d = (rx_byte_i == TrailerByte);
    end
    for (int i = 0; i < FieldCount; i++) begin
      if (pos_q == 8'(FieldFirst + i)) begin
        field_d[i] = rx_byte_i;
      end
    end
    if (pos_q < CrcPos) begin
      crc_d = crc8_step(crc_q, rx_byte_i);
    end else if (pos_q == CrcPos) begin
      crc_ok_d = (crc_q == rx_byte_i);
    end
    pos_d  = len;
    mark_d = (rx_byte_i == MarkFirst);

    res.accel_x      = {field_d[0], field_d[1]};
    res.accel_y      = {field_d[2], field_d[3]};
    res.accel_z      = {field_d[4], field_d[5]};
    res.time_stamp   = {field_d[6], field_d[7], field_d[8], field_d[9]};
    res.speed_byte   = field_d[10];
    res.gyro_x       = {field_d[11], field_d[12]};
    res.gyro_y       = {field_d[13], field_d[14]};
    res.gyro_z       = {field_d[15], field_d[16]};
    res.crc_good     = crc_ok_d;
    res.markers_good = hdr_d && trl_d;
    res.frame_length = len;
    res.length_good  = (len >= MinLength);

    if (frame_end) begin
      pos_d    = 8'd0;
      mark_d   = 1'b0;
      crc_d    = 8'd0;
      crc_ok_d = 1'b0;
      hdr_d    = 1'b0;
      trl_d    = 1'b0;
      for (int i = 0; i < FieldCount; i++) begin
        field_d[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 8'd0;
      mark_q   <= 1'b0;
      crc_q    <= 8'd0;
      crc_ok_q <= 1'b0;
      hdr_q    <= 1'b0;
      trl_q    <= 1'b0;
      for (int i = 0; i < FieldCount; i++) begin
        field_q[i] <= 8'd0;
      end
    end else if (accept) begin
      pos_q    <= pos_d;
      mark_q   <= mark_d;
      crc_q    <= crc_d;
      crc_ok_q <= crc_ok_d;
      hdr_q    <= hdr_d;
      trl_q    <= trl_d;
      field_q  <= field_d;
    end
  end

  imu_fd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (frame_end),
    .res_i       (res),
    .skid_full_o (skid_full),
    .out_valid_o (frame_valid_o),
    .out_res_o   (out_res),
    .out_stall_i (frame_stall_i)
  );

  assign rx_stall_o     = skid_full;
  assign accel_x_o      = out_res.accel_x;
  assign accel_y_o      = out_res.accel_y;
  assign accel_z_o      = out_res.accel_z;
  assign time_stamp_o   = out_res.time_stamp;
  assign speed_byte_o   = out_res.speed_byte;
  assign gyro_x_o       = out_res.gyro_x;
  assign gyro_y_o       = out_res.gyro_y;
  assign gyro_z_o       = out_res.gyro_z;
  assign crc_good_o     = out_res.crc_good;
  assign markers_good_o = out_res.markers_good;
  assign frame_length_o = out_res.frame_length;
  assign length_good_o  = out_res.length_good;

endmodule

`default_nettype wire
